// File: rtl/qtyr_pkg.sv
// Package: shared types, constants and the CORDIC angle table for quaternion to yaw/roll.
package qtyr_pkg;

	localparam int unsigned DEF_CORDIC_STEPS    = 16;
	localparam int unsigned DEF_COMPONENT_WIDTH = 16;

	// Effective component width after pre-shift of wide inputs
	localparam int unsigned MAX_EFF_WIDTH = 24;
	// Datapath width inside the CORDIC (args up to ~2^48 times 4096, plus growth)
	localparam int unsigned CW = 66;
	// Angle accumulator width, 65536 units per degree
	localparam int unsigned ZW = 28;
	localparam int unsigned OUT_W = 16;
	localparam int unsigned ARG_SHIFT = 12;
	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);
	localparam logic [OUT_W-1:0] FULL_TURN_OUT = 16'd46080;

	typedef struct packed {
		logic [DEF_COMPONENT_WIDTH-1:0] quat_real;
		logic [DEF_COMPONENT_WIDTH-1:0] quat_i;
		logic [DEF_COMPONENT_WIDTH-1:0] quat_j;
		logic [DEF_COMPONENT_WIDTH-1:0] quat_k;
	} quat_req_t;

	typedef struct packed {
		logic [OUT_W-1:0] yaw_deg;
		logic [OUT_W-1:0] roll_deg;
	} angle_res_t;

	// atan(2^-i) in degrees times 65536
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0: r = 2949120; 1: r = 1740967; 2: r = 919879; 3: r = 466945;
			4: r = 234379;  5: r = 117304;  6: r = 58666;  7: r = 29335;
			8: r = 14668;   9: r = 7334;    10: r = 3667;  11: r = 1833;
			12: r = 917;    13: r = 458;    14: r = 229;   15: r = 115;
			16: r = 57;     17: r = 29;     18: r = 14;    19: r = 7;
			20: r = 4;      21: r = 2;      22: r = 1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/qtyr_args.sv
// Argument stages: component products (stage 1) and atan2 argument sums (stage 2).
module qtyr_args import qtyr_pkg::*; #(
	parameter int unsigned COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic [COMPONENT_WIDTH-1:0] c_r,
	input  logic [COMPONENT_WIDTH-1:0] c_i,
	input  logic [COMPONENT_WIDTH-1:0] c_j,
	input  logic [COMPONENT_WIDTH-1:0] c_k,
	output logic out_vld,
	output logic signed [CW-1:0] yaw_y,
	output logic signed [CW-1:0] yaw_x,
	output logic signed [CW-1:0] roll_y,
	output logic signed [CW-1:0] roll_x
);
	localparam int unsigned SH = (COMPONENT_WIDTH > MAX_EFF_WIDTH) ?
		COMPONENT_WIDTH - MAX_EFF_WIDTH : 0;
	localparam int unsigned EW = COMPONENT_WIDTH - SH;
	localparam int unsigned PW = 2 * EW;

	logic signed [EW-1:0] r, qi, qj, qk;
	logic signed [PW-1:0] rr_s1, ii_s1, jj_s1, kk_s1, ij_s1, kr_s1, jk_s1, ir_s1;
	logic vld_s1, vld_s2;
	logic signed [CW-1:0] yy_s2, yx_s2, ry_s2, rx_s2;

	// Pre-shift of wide components, floor
	assign r  = EW'($signed(c_r) >>> SH);
	assign qi = EW'($signed(c_i) >>> SH);
	assign qj = EW'($signed(c_j) >>> SH);
	assign qk = EW'($signed(c_k) >>> SH);

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_vld;
	end

	// Stage 1 products
	always_ff @(posedge clk) begin
		rr_s1 <= PW'(r * r);   ii_s1 <= PW'(qi * qi);
		jj_s1 <= PW'(qj * qj); kk_s1 <= PW'(qk * qk);
		ij_s1 <= PW'(qi * qj); kr_s1 <= PW'(qk * r);
		jk_s1 <= PW'(qj * qk); ir_s1 <= PW'(qi * r);
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	// Stage 2 sums, scaled by 4096 (x2 included for y terms)
	always_ff @(posedge clk) begin
		yy_s2 <= (CW'(ij_s1) + CW'(kr_s1)) <<< (ARG_SHIFT + 1);
		yx_s2 <= (CW'(ii_s1) - CW'(jj_s1) - CW'(kk_s1) + CW'(rr_s1)) <<< ARG_SHIFT;
		ry_s2 <= (CW'(jk_s1) + CW'(ir_s1)) <<< (ARG_SHIFT + 1);
		rx_s2 <= (CW'(kk_s1) + CW'(rr_s1) - CW'(ii_s1) - CW'(jj_s1)) <<< ARG_SHIFT;
	end

	assign out_vld = vld_s2;
	assign yaw_y = yy_s2;
	assign yaw_x = yx_s2;
	assign roll_y = ry_s2;
	assign roll_x = rx_s2;
endmodule

// File: rtl/qtyr_cordic.sv
// Pipelined vectoring CORDIC: atan2 then negate, round and wrap to 1/128 degree.
module qtyr_cordic import qtyr_pkg::*; #(
	parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	output logic out_vld,
	output logic [OUT_W-1:0] angle
);
	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
	logic zero_s [CORDIC_STEPS+1];
	logic vld_s [CORDIC_STEPS+1];
	logic [OUT_W-1:0] out_q;
	logic out_vld_q;
	logic signed [ZW-1:0] zf, rnd, wrap;

	// Pre-rotation stage: half turn for negative x
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else vld_s[0] <= in_vld;
	end
	always_ff @(posedge clk) begin
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in < 0) begin
			x_s[0] <= -x_in;
			y_s[0] <= -y_in;
			z_s[0] <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
		end else begin
			x_s[0] <= x_in;
			y_s[0] <= y_in;
			z_s[0] <= '0;
		end
	end

	// One micro-rotation per stage
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g+1] <= 1'b0;
			else vld_s[g+1] <= vld_s[g];
		end
		always_ff @(posedge clk) begin
			zero_s[g+1] <= zero_s[g];
			if (y_s[g] > 0) begin
				x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
				z_s[g+1] <= z_s[g] + atan_entry(g);
			end else begin
				x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
				z_s[g+1] <= z_s[g] - atan_entry(g);
			end
		end
	end

	// Negate, round half up to 1/128 degree, wrap into one turn
	always_comb begin
		zf   = zero_s[CORDIC_STEPS] ? '0 : z_s[CORDIC_STEPS];
		rnd  = (ZW'(256) - zf) >>> 9;
		wrap = rnd;
		if (wrap < 0) wrap = wrap + ZW'(FULL_TURN_OUT);
		if (wrap >= ZW'(FULL_TURN_OUT)) wrap = wrap - ZW'(FULL_TURN_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else out_vld_q <= vld_s[CORDIC_STEPS];
	end
	always_ff @(posedge clk) out_q <= wrap[OUT_W-1:0];

	assign out_vld = out_vld_q;
	assign angle = out_q;

	// Result always within one turn
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q < FULL_TURN_OUT)) else $error("angle out of range");
	// Zero vector gives a zero angle
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[CORDIC_STEPS] && zero_s[CORDIC_STEPS]) |=> (out_q == '0))
		else $error("zero vector not zero");
	// Valid leaves the pipeline a fixed latency after entry
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> ##(CORDIC_STEPS+1) out_vld_q) else $error("valid lost");
endmodule

// File: rtl/quaternion_to_yaw_roll_degrees.sv
// Top level: quaternion to negated yaw and roll in 1/128 degree, fully pipelined.
//  channel | signals               | handshake
//  request | start, busy, req      | taken when start && !busy
//  result  | done, res             | done high one cycle, no back-pressure
// One request per cycle; busy is tied low because the pipeline never stalls.
// Pipeline: 2 argument stages + 1 pre-rotation + CORDIC_STEPS rotations + 1 output stage.
// Reset clears all valid bits; data registers are not reset.
// The receiver cannot stall, so no request is ever held back.
module quaternion_to_yaw_roll_degrees import qtyr_pkg::*; #(
	parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  quat_req_t req,
	output logic done,
	output angle_res_t res
);
	logic a_vld, y_vld, r_vld;
	logic signed [CW-1:0] yy, yx, ry, rx;

	assign busy = 1'b0;

	// Component width follows the request struct in the package
	qtyr_args #(.COMPONENT_WIDTH(DEF_COMPONENT_WIDTH)) u_args (
		.clk, .arst_n, .in_vld(start),
		.c_r(req.quat_real), .c_i(req.quat_i),
		.c_j(req.quat_j), .c_k(req.quat_k),
		.out_vld(a_vld), .yaw_y(yy), .yaw_x(yx), .roll_y(ry), .roll_x(rx)
	);

	qtyr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
		.clk, .arst_n, .in_vld(a_vld), .y_in(yy), .x_in(yx),
		.out_vld(y_vld), .angle(res.yaw_deg)
	);

	qtyr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk, .arst_n, .in_vld(a_vld), .y_in(ry), .x_in(rx),
		.out_vld(r_vld), .angle(res.roll_deg)
	);

	assign done = y_vld & r_vld;
endmodule

// File: bench/quaternion_to_yaw_roll_degrees_tb.sv
// Testbench: quaternion to negated yaw/roll degrees, with a CORDIC angle predictor.
module quaternion_to_yaw_roll_degrees_tb;
	import qtyr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DEPTH = 2 + 1 + DEF_CORDIC_STEPS + 1;
	localparam longint ONE_DEG = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	quat_req_t req = '0;
	logic done;
	angle_res_t res;

	angle_res_t angles_due[$];
	int errors = 0;
	bit steady = 1'b0;

	quaternion_to_yaw_roll_degrees dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .res(res)
	);

	always #6 clk = ~clk;

	// CORDIC table, atan(2^-i) in 1/65536 degree
	function automatic longint atan_deg(int i);
		longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		return (i < 23) ? t[i] : 0;
	endfunction

	// Vectoring CORDIC atan2, angle in 1/65536 degree
	function automatic longint vector_angle(longint y, longint x);
		longint z = 0;
		longint dx, dy;
		if (x == 0 && y == 0)
			return 0;
		x = x * 4096;
		y = y * 4096;
		if (x < 0) begin
			z = (y >= 0) ? 180 * ONE_DEG : -180 * ONE_DEG;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_deg(i);
			end else begin
				x -= dx; y += dy; z -= atan_deg(i);
			end
		end
		return z;
	endfunction

	// Negate, round to 1/128 degree and wrap into one turn
	function automatic logic [OUT_W-1:0] wrap_degrees(longint z);
		longint r = (-z + 256) >>> 9;
		if (r < 0) r += FULL_TURN_OUT;
		if (r >= FULL_TURN_OUT) r -= FULL_TURN_OUT;
		return OUT_W'(r);
	endfunction

	function automatic angle_res_t predict_angles(quat_req_t q);
		longint r, a, b, c;
		angle_res_t o;
		r = longint'($signed(q.quat_real));
		a = longint'($signed(q.quat_i));
		b = longint'($signed(q.quat_j));
		c = longint'($signed(q.quat_k));
		o.yaw_deg = wrap_degrees(vector_angle(2 * (a * b + c * r),
			a * a - b * b - c * c + r * r));
		o.roll_deg = wrap_degrees(vector_angle(2 * (b * c + a * r),
			-a * a - b * b + c * c + r * r));
		return o;
	endfunction

	// Log accepted requests, then check each result against the oldest one due
	always @(posedge clk) begin
		angle_res_t want;
		if (start && !busy)
			angles_due.push_back(predict_angles(req));
		if (done) begin
			if (angles_due.size() == 0) begin
				$display("%t unexpected result yaw=%0d roll=%0d", $time,
					res.yaw_deg, res.roll_deg);
				errors++;
			end else begin
				want = angles_due.pop_front();
				if (res.yaw_deg !== want.yaw_deg) begin
					$display("%t yaw_deg expected %0d actual %0d", $time,
						want.yaw_deg, res.yaw_deg);
					errors++;
				end
				if (res.roll_deg !== want.roll_deg) begin
					$display("%t roll_deg expected %0d actual %0d", $time,
						want.roll_deg, res.roll_deg);
					errors++;
				end
			end
		end
	end

	// Drive one request and hold it until taken; then idle each cycle with 36% odds
	task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
			logic [15:0] z);
		@(negedge clk);
		start <= 1'b1;
		req <= '{quat_real: w, quat_i: x, quat_j: y, quat_k: z};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		while (!steady && $urandom_range(99) < 36) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (angles_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extremes();
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_quat(16'h8000, 16'h0000, 16'h0000, 16'h7fff);
		send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
	endtask

	task automatic test_special_cases();
		// zero quaternion: both arguments zero
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// negative x with zero y: half turn (yaw and roll, then roll only)
		send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
		send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
		// small negative angle rounds up towards a full turn; the last request mirrors it to a small positive angle
		send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0001);
		send_quat(16'h4000, 16'h0001, 16'h0000, 16'h0000);
		send_quat(16'h4000, 16'hffff, 16'h0000, 16'hffff);
		// unnormalised quaternions; the first two are scaled versions of one rotation
		send_quat(16'h2d41, 16'h0000, 16'h0000, 16'h2d41);
		send_quat(16'h0003, 16'h0000, 16'h0000, 16'h0003);
		send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
		send_quat(16'he000, 16'h2000, 16'he000, 16'h2000);
	endtask

	// Mostly unit-range components, some full-range noise
	task automatic test_random(int count);
		logic [15:0] c[4];
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 4; k++)
				c[k] = ($urandom_range(99) < 70) ? 16'($signed($urandom_range(32768)) - 16384)
					: 16'($urandom);
			send_quat(c[0], c[1], c[2], c[3]);
		end
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		test_random(300);
		steady = 1'b0;
	endtask

	task automatic test_pause_until_empty();
		test_random(20);
		wait_drained();
		test_random(20);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_special_cases();
		test_random(600);
		test_back_to_back();
		test_pause_until_empty();
		test_random(540);
		wait_drained();
		repeat (PIPE_DEPTH + 5) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

endmodule
